[sv/iiat_pkg.sv]
// shared types and constants for the integral image threshold block
package iiat_pkg;

	localparam int MAX_HEIGHT_DEF = 128;
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int INT_W  = 23;
	localparam int SUM_W  = 26;
	localparam int AREA_W = 22;

	localparam logic [1:0] REG_HEIGHT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;
	localparam logic [1:0] REG_OFFSET = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_Q_SETUP,
		ST_Q_RD_D,
		ST_Q_RD_B,
		ST_Q_RD_C,
		ST_Q_RD_A,
		ST_Q_RD_P,
		ST_Q_DIV,
		ST_Q_CMP,
		ST_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       capture;
		logic       load_rd;
		logic       load_wr;
		logic       q_setup;
		logic [2:0] rd_sel;
		logic       rd_go;
		logic       div_start;
		logic       cmp;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic is_load;
		logic q_ok;
		logic div_done;
	} sts_t;

	localparam logic [2:0] SEL_D = 3'd0;
	localparam logic [2:0] SEL_B = 3'd1;
	localparam logic [2:0] SEL_C = 3'd2;
	localparam logic [2:0] SEL_A = 3'd3;
	localparam logic [2:0] SEL_P = 3'd4;

endpackage

[sv/iiat_ram.sv]
// generic single-port ram with registered read
module iiat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[sv/iiat_ctrl.sv]
// controller state machine sequencing loads and queries
module iiat_ctrl import iiat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_Q_SETUP;
				end
			end
			ST_Q_SETUP: begin
				if (sts.is_load) begin
					cmd.load_rd = 1'b1;
					state_d = ST_LD_RD;
				end else begin
					cmd.q_setup = 1'b1;
					state_d = sts.q_ok ? ST_Q_RD_D : ST_OUT;
				end
			end
			ST_LD_RD: begin
				cmd.load_rd = 1'b1;
				state_d = ST_LD_WR;
			end
			ST_LD_WR: begin
				cmd.load_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_Q_RD_D: begin
				cmd.rd_sel = SEL_D; cmd.rd_go = 1'b1; state_d = ST_Q_RD_B;
			end
			ST_Q_RD_B: begin
				cmd.rd_sel = SEL_B; cmd.rd_go = 1'b1; state_d = ST_Q_RD_C;
			end
			ST_Q_RD_C: begin
				cmd.rd_sel = SEL_C; cmd.rd_go = 1'b1; state_d = ST_Q_RD_A;
			end
			ST_Q_RD_A: begin
				cmd.rd_sel = SEL_A; cmd.rd_go = 1'b1; state_d = ST_Q_RD_P;
			end
			ST_Q_RD_P: begin
				cmd.rd_sel = SEL_P; cmd.rd_go = 1'b1; state_d = ST_Q_DIV;
			end
			ST_Q_DIV: begin
				cmd.div_start = 1'b0;
				if (sts.div_done) state_d = ST_Q_CMP;
			end
			ST_Q_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_Q_RD_P) cmd.div_start = 1'b1;
	end
endmodule

[sv/iiat_div.sv]
// restoring divider of a signed window sum by an unsigned area, truncating toward zero
module iiat_div import iiat_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [AREA_W-1:0]       divisor,
	output logic                    done,
	output logic signed [SUM_W:0]   quotient
);
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  mag_q;
	logic [SUM_W-1:0]  quo_q;
	logic [SUM_W:0]    rem_q;
	logic [AREA_W-1:0] dvs_q;
	logic              neg_q;
	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W:0]    shifted;
	logic [SUM_W:0]    diff;
	logic [SUM_W-1:0]  mag_in;

	assign mag_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign shifted = {rem_q[SUM_W-1:0], mag_q[SUM_W-1]};
	assign diff    = shifted - (SUM_W+1)'(dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_W-2:0], 1'b0};
			if (!diff[SUM_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

[sv/iiat_dp.sv]
// datapath: registers, address generation, stores, window sum and compare
module iiat_dp import iiat_pkg::*; #(
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       mode,
	input  logic [7:0] pixel,
	input  logic [6:0] row,
	input  logic [7:0] column,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       binary,
	output logic       valid_res
);
	localparam int RW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
	localparam int AW = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int XW = 11;

	logic [7:0] height_q, window_q;
	logic [8:0] width_q;
	logic signed [8:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 8'd120;
			width_q  <= 9'd188;
			window_q <= 8'd15;
			offset_q <= 9'sd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEIGHT: height_q <= cfg_data[7:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_WINDOW: window_q <= cfg_data[7:0];
				REG_OFFSET: offset_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	logic [XW-1:0] h_eff, w_eff;
	always_comb begin
		if (height_q == 8'd0) h_eff = XW'(1);
		else if (XW'(height_q) > XW'(MAX_HEIGHT)) h_eff = XW'(MAX_HEIGHT);
		else h_eff = XW'(height_q);
		if (width_q == 9'd0) w_eff = XW'(1);
		else if (XW'(width_q) > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
		else w_eff = XW'(width_q);
	end

	// captured beat
	logic       mode_q;
	logic [7:0] pix_q;
	logic [XW-1:0] y_q, x_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			pix_q  <= pixel;
			y_q    <= XW'(row);
			x_q    <= XW'(column);
		end
	end

	// load position state
	logic [XW-1:0] lrow_q, lcol_q;
	logic [15:0]   rsum_q;
	logic          done_q;
	logic [XW-1:0] lr, lc;
	logic [15:0]   rs_new;
	always_comb begin
		lr = done_q ? '0 : lrow_q;
		lc = done_q ? '0 : lcol_q;
		if (lr >= XW'(MAX_HEIGHT)) lr = XW'(MAX_HEIGHT - 1);
		if (lc >= XW'(MAX_WIDTH))  lc = XW'(MAX_WIDTH - 1);
		rs_new = (done_q ? 16'd0 : rsum_q) + 16'(pix_q);
	end

	// window geometry
	logic [XW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [AREA_W-1:0] area_q;
	logic [XW-1:0] half, x1, y1, x2, y2;
	always_comb begin
		half = XW'(window_q[7:1]);
		x1 = (x_q > half) ? x_q - half : '0;
		y1 = (y_q > half) ? y_q - half : '0;
		x2 = (x_q + half < w_eff - 1'b1) ? x_q + half : w_eff - 1'b1;
		y2 = (y_q + half < h_eff - 1'b1) ? y_q + half : h_eff - 1'b1;
	end

	// store addressing
	logic [XW-1:0] ar, ac;
	logic [AW-1:0] addr;
	logic          int_we, pix_we;
	logic [INT_W-1:0] int_rd, int_wd;
	logic [7:0]    pix_rd;
	always_comb begin
		ar = lr;
		ac = lc;
		if (cmd.load_rd) begin
			ar = lr - 1'b1;
		end else if (cmd.rd_go) begin
			case (cmd.rd_sel)
				SEL_D: begin ar = y2_q; ac = x2_q; end
				SEL_B: begin ar = y1_q - 1'b1; ac = x2_q; end
				SEL_C: begin ar = y2_q; ac = x1_q - 1'b1; end
				SEL_A: begin ar = y1_q - 1'b1; ac = x1_q - 1'b1; end
				SEL_P: begin ar = y_q; ac = x_q; end
				default: ;
			endcase
		end
		addr   = {ar[RW-1:0], ac[CW-1:0]};
		int_we = cmd.load_wr;
		pix_we = cmd.load_wr;
	end

	logic top_row_q;
	assign int_wd = (top_row_q ? INT_W'(0) : int_rd) + INT_W'(rs_new);

	iiat_ram #(.WIDTH(INT_W), .DEPTH(DEPTH)) u_int (
		.clk(clk), .we(int_we), .addr(addr), .wdata(int_wd), .rdata(int_rd)
	);
	iiat_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pix (
		.clk(clk), .we(pix_we), .addr(addr), .wdata(pix_q), .rdata(pix_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lrow_q <= '0;
			lcol_q <= '0;
			rsum_q <= '0;
			done_q <= 1'b0;
		end else if (cmd.load_wr) begin
			if (lc + 1'b1 >= w_eff) begin
				lcol_q <= '0;
				rsum_q <= '0;
				if (lr + 1'b1 >= h_eff) begin
					lrow_q <= '0;
					done_q <= 1'b1;
				end else begin
					lrow_q <= lr + 1'b1;
					done_q <= 1'b0;
				end
			end else begin
				lcol_q <= lc + 1'b1;
				rsum_q <= rs_new;
				done_q <= 1'b0;
			end
		end
	end

	// window sum accumulation; store reads are registered, so select and go are registered to match
	logic [2:0] sel_s1;
	logic       go_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic [7:0] pval_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_s1 <= 1'b0;
		else go_s1 <= cmd.rd_go;
	end
	always_ff @(posedge clk) begin
		sel_s1 <= cmd.rd_sel;
		if (cmd.load_rd) top_row_q <= (lr == '0);
		if (cmd.q_setup) begin
			x1_q <= x1; y1_q <= y1; x2_q <= x2; y2_q <= y2;
			area_q <= AREA_W'(x2 - x1 + 1'b1) * AREA_W'(y2 - y1 + 1'b1);
			sum_q  <= '0;
		end
		if (go_s1) begin
			case (sel_s1)
				SEL_D: sum_q <= sum_q + SUM_W'(int_rd);
				SEL_B: if (y1_q != '0) sum_q <= sum_q - SUM_W'(int_rd);
				SEL_C: if (x1_q != '0) sum_q <= sum_q - SUM_W'(int_rd);
				SEL_A: if (x1_q != '0 && y1_q != '0) sum_q <= sum_q + SUM_W'(int_rd);
				SEL_P: pval_q <= pix_rd;
				default: ;
			endcase
		end
	end

	logic signed [SUM_W:0] mean;
	logic div_start_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_start_s1 <= 1'b0;
		else div_start_s1 <= cmd.div_start;
	end

	iiat_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_s1),
		.dividend(sum_q), .divisor(area_q), .done(sts.div_done), .quotient(mean)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			binary    <= 1'b0;
			valid_res <= 1'b0;
		end else if (cmd.q_setup) begin
			binary    <= 1'b0;
			valid_res <= sts.q_ok;
		end else if (cmd.cmp) begin
			binary <= !($signed({(SUM_W+2)'(0), pval_q}) <
				(SUM_W+10)'(mean) + (SUM_W+10)'(offset_q));
		end
	end

	assign sts.is_load = !mode_q;
	assign sts.q_ok    = done_q && (y_q < h_eff) && (x_q < w_eff);
endmodule

[sv/integral_image_adaptive_threshold_top.sv]
// top level of the integral image adaptive mean threshold block
//
//  channel | signals                            | role
//  in      | in_valid in_stall mode pixel row column | load or query beat
//  out     | out_valid out_stall binary valid_res     | one beat per query
//  cfg     | cfg_we cfg_index cfg_data              | register write
//
// a load passes through capture, decode, read of the entry above and write
// a query inside a complete frame passes through decode, five reads of the single-port
// stores, a bit-serial divide of the window sum by its area (26 steps), compare and
// output; any other query goes from decode straight to output
// reset clears the load position and the frame flag and sets the registers to
// their defaults; stores are left as they are; a query result waits in the output
// register under out_stall and no new beat is taken until it goes
module integral_image_adaptive_threshold_top import iiat_pkg::*; #(
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] pixel,
	input  logic [6:0] row,
	input  logic [7:0] column,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       binary,
	output logic       valid_res,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	// sequencing of every beat
	iiat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	// stores, arithmetic and result register
	iiat_dp #(.MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .mode(mode), .pixel(pixel), .row(row),
		.column(column), .cmd(cmd), .sts(sts), .binary(binary),
		.valid_res(valid_res)
	);
endmodule

[sv/iiat_chk.sv]
// port checker for the threshold block and its bind
module iiat_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic binary,
	input logic valid_res
);
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second beat taken at once");
	a_no_take_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(binary) && $stable(valid_res))
		else $error("stalled result changed");
	a_invalid_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> !binary) else $error("invalid result not black");
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid) else $error("result repeated");
endmodule

bind integral_image_adaptive_threshold_top iiat_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .binary(binary),
	.valid_res(valid_res)
);

[test/tb_integral_image_adaptive_threshold_top.sv]
// self-checking testbench for the integral image adaptive mean threshold block
module tb_integral_image_adaptive_threshold_top import iiat_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_H = 128;
	localparam int MAX_W = 256;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		bit       mode;
		bit [7:0] pixel;
		bit [6:0] row;
		bit [7:0] column;
	} beat_t;

	typedef struct {
		bit binary;
		bit valid_res;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       mode = 1'b0;
	logic [7:0] pixel = '0;
	logic [6:0] row = '0;
	logic [7:0] column = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       binary;
	logic       valid_res;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_HEIGHT;
	logic [8:0] cfg_data = '0;

	integral_image_adaptive_threshold_top uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mirror of the block: stores, load position and registers
	bit [7:0]  gray_mem [MAX_H*MAX_W];
	bit [22:0] sum_mem [MAX_H*MAX_W];
	bit        wr_mem [MAX_H*MAX_W];
	int unsigned row_acc, ld_row, ld_col;
	bit frame_done;
	int unsigned cfg_h = 120, cfg_w = 188, cfg_win = 15;
	logic signed [8:0] cfg_off = '0;

	beat_t pend_beats[$];
	verdict_t verdicts_due[$];

	bit in_taken;
	bit quiet;
	bit hold_req;
	int hold_cnt;
	int idle_cycles;
	int fail_cnt, query_cnt, load_cnt, result_cnt, stim_cnt;

	function automatic int unsigned eff_h();
		return (cfg_h < 1) ? 1 : (cfg_h > MAX_H) ? MAX_H : cfg_h;
	endfunction

	function automatic int unsigned eff_w();
		return (cfg_w < 1) ? 1 : (cfg_w > MAX_W) ? MAX_W : cfg_w;
	endfunction

	// integral update for one loaded pixel
	function automatic void absorb_pixel(bit [7:0] p);
		int unsigned r, c, above;
		if (frame_done) begin
			frame_done = 0;
			ld_row = 0;
			ld_col = 0;
			row_acc = 0;
		end
		r = (ld_row >= MAX_H) ? MAX_H - 1 : ld_row;
		c = (ld_col >= MAX_W) ? MAX_W - 1 : ld_col;
		row_acc = (row_acc + p) & 16'hFFFF;
		above = (r > 0) ? sum_mem[(r-1)*MAX_W + c] : 0;
		gray_mem[r*MAX_W + c] = p;
		sum_mem[r*MAX_W + c] = 23'(above + row_acc);
		wr_mem[r*MAX_W + c] = 1;
		if (c + 1 >= eff_w()) begin
			ld_col = 0;
			row_acc = 0;
			if (r + 1 >= eff_h()) begin
				ld_row = 0;
				frame_done = 1;
			end else
				ld_row = r + 1;
		end else
			ld_col = c + 1;
	endfunction

	// checks that a query only touches entries that have been loaded at some point
	function automatic bit reads_known(int unsigned y, int unsigned x);
		int unsigned h, w, half, x1, y1, x2, y2;
		bit ok;
		h = eff_h();
		w = eff_w();
		if (!frame_done || y >= h || x >= w)
			return 1;
		half = cfg_win / 2;
		x1 = (x > half) ? x - half : 0;
		y1 = (y > half) ? y - half : 0;
		x2 = (x + half < w - 1) ? x + half : w - 1;
		y2 = (y + half < h - 1) ? y + half : h - 1;
		ok = wr_mem[y2*MAX_W + x2] && wr_mem[y*MAX_W + x];
		if (y1 > 0)
			ok = ok && wr_mem[(y1-1)*MAX_W + x2];
		if (x1 > 0)
			ok = ok && wr_mem[y2*MAX_W + x1 - 1];
		if (x1 > 0 && y1 > 0)
			ok = ok && wr_mem[(y1-1)*MAX_W + x1 - 1];
		return ok;
	endfunction

	// windowed mean and threshold decision for one queried pixel
	function automatic verdict_t threshold_pixel(int unsigned y, int unsigned x);
		verdict_t v;
		int unsigned h, w, half, x1, y1, x2, y2;
		longint a, b, cc, d, total, area, mean;
		h = eff_h();
		w = eff_w();
		v.binary = 0;
		v.valid_res = 0;
		if (!frame_done || y >= h || x >= w)
			return v;
		half = cfg_win / 2;
		x1 = (x > half) ? x - half : 0;
		y1 = (y > half) ? y - half : 0;
		x2 = (x + half < w - 1) ? x + half : w - 1;
		y2 = (y + half < h - 1) ? y + half : h - 1;
		area = longint'(x2 - x1 + 1) * longint'(y2 - y1 + 1);
		a = (x1 > 0 && y1 > 0) ? sum_mem[(y1-1)*MAX_W + x1 - 1] : 0;
		b = (y1 > 0) ? sum_mem[(y1-1)*MAX_W + x2] : 0;
		cc = (x1 > 0) ? sum_mem[y2*MAX_W + x1 - 1] : 0;
		d = sum_mem[y2*MAX_W + x2];
		total = d - b - cc + a;
		mean = total / area;
		v.valid_res = 1;
		v.binary = (longint'(gray_mem[y*MAX_W + x]) < mean + longint'(cfg_off)) ? 0 : 1;
		return v;
	endfunction

	// input driver: a new beat only once the current one has been taken
	always @(negedge clk) begin
		beat_t b;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pend_beats.size() != 0 && !(!quiet && $urandom_range(99) < 37)) begin
				b = pend_beats.pop_front();
				mode <= b.mode;
				pixel <= b.pixel;
				row <= b.row;
				column <= b.column;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// output back-pressure, with a long hold when asked
	always @(negedge clk) begin
		if (hold_req && hold_cnt == 0) begin
			hold_cnt = LONG_HOLD;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else
			out_stall <= !quiet && $urandom_range(99) < 37;
	end

	// monitor: predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin
		verdict_t got, want;
		bit moved;
		moved = 0;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			moved = 1;
			if (mode == 1'b0)
				absorb_pixel(pixel);
			else
				verdicts_due.push_back(threshold_pixel(row, column));
		end
		if (arst_n && out_valid && !out_stall) begin
			moved = 1;
			result_cnt++;
			got.binary = binary;
			got.valid_res = valid_res;
			if (verdicts_due.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected result beat binary=%0b valid_res=%0b",
					$realtime, binary, valid_res);
			end else begin
				want = verdicts_due.pop_front();
				if (got.valid_res !== want.valid_res) begin
					fail_cnt++;
					$display("%0t: valid_res expected %0b actual %0b",
						$realtime, want.valid_res, valid_res);
				end
				if (got.binary !== want.binary) begin
					fail_cnt++;
					$display("%0t: binary expected %0b actual %0b",
						$realtime, want.binary, binary);
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress, %0d results still due", $realtime, verdicts_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_load(bit [7:0] p);
		beat_t b;
		b.mode = 0;
		b.pixel = p;
		b.row = 7'($urandom);
		b.column = 8'($urandom);
		pend_beats.push_back(b);
		load_cnt++;
		stim_cnt++;
	endtask

	task automatic push_query(bit [6:0] r, bit [7:0] c);
		beat_t b;
		b.mode = 1;
		b.pixel = 8'($urandom);
		b.row = r;
		b.column = c;
		pend_beats.push_back(b);
		query_cnt++;
		stim_cnt++;
	endtask

	// drain everything, then give the last load time to finish
	task automatic drain();
		do @(posedge clk);
		while (pend_beats.size() != 0 || in_valid || verdicts_due.size() != 0);
		repeat (50) @(posedge clk);
	endtask

	// all four registers, one per falling edge; mirror follows at once
	task automatic set_regs(int unsigned h, int unsigned w, int unsigned win, int off);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_HEIGHT;
		cfg_data <= 9'(h);
		@(negedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data <= 9'(w);
		@(negedge clk);
		cfg_index <= REG_WINDOW;
		cfg_data <= 9'(win);
		@(negedge clk);
		cfg_index <= REG_OFFSET;
		cfg_data <= 9'(off);
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_h = h & 8'hFF;
		cfg_w = w & 9'h1FF;
		cfg_win = win & 8'hFF;
		cfg_off = 9'(off);
	endtask

	task automatic load_frame(bit random_pix);
		int n;
		n = eff_h() * eff_w();
		for (int i = 0; i < n; i++)
			push_load(random_pix ? 8'($urandom) : ((i % 2) ? 8'hFF : 8'h00));
	endtask

	initial begin
		int unsigned h, w, qr, qc;
		int k;
		bit fresh;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no frame yet: every query is invalid
		push_query(0, 0);
		push_query(127, 255);
		push_query(60, 100);
		drain();

		// tiny frame, alternating black and white
		set_regs(4, 5, 3, 0);
		load_frame(0);
		for (int i = 0; i < 6; i++)
			push_query(7'($urandom_range(5)), 8'($urandom_range(6)));
		drain();
		set_regs(4, 5, 0, -255);
		push_query(1, 1);
		push_query(3, 4);
		drain();
		set_regs(4, 5, 255, 255);
		push_query(2, 2);
		push_query(0, 4);
		drain();

		// zero sizes act as one
		set_regs(0, 0, 1, 1);
		push_load(8'd77);
		push_query(0, 0);
		push_query(0, 1);
		push_query(1, 0);
		drain();

		// long receiver hold while the sender keeps offering queries
		set_regs(8, 10, 5, 3);
		load_frame(1);
		drain();
		hold_req = 1;
		for (int i = 0; i < 10; i++)
			push_query(7'($urandom_range(7)), 8'($urandom_range(9)));
		drain();

		// random phases
		while (stim_cnt < 1900) begin
			quiet = ($urandom_range(9) == 0);
			fresh = 0;
			k = $urandom_range(99);
			h = (k < 5) ? 0 : (k < 10) ? $urandom_range(255, 129) : $urandom_range(12, 1);
			k = $urandom_range(99);
			w = (k < 5) ? 0 : (k < 10) ? $urandom_range(511, 257) : $urandom_range(16, 1);
			set_regs(h, w, $urandom_range(255) % (($urandom_range(3) == 0) ? 256 : 12),
				$urandom_range(510) - 255);
			if (eff_h() * eff_w() <= 256) begin
				fresh = 1;
				if ($urandom_range(4) == 0 && eff_h() * eff_w() > 2) begin
					// part of a frame, then a size no larger, and finish under the new size
					for (int i = 0; i < eff_h() * eff_w() / 2; i++)
						push_load(8'($urandom));
					push_query(7'($urandom_range(3)), 8'($urandom_range(3)));
					drain();
					set_regs($urandom_range(eff_h(), 1), $urandom_range(eff_w(), 1),
						cfg_win, cfg_off);
					while (!frame_done) begin
						push_load(8'($urandom));
						drain();
					end
				end else
					load_frame(1);
			end
			for (int i = 0; i < 15; i++) begin
				if ($urandom_range(99) < 85) begin
					qr = $urandom_range(eff_h() - 1);
					qc = $urandom_range(eff_w() - 1);
				end else begin
					qr = $urandom_range(127);
					qc = $urandom_range(255);
				end
				// without a new frame, stay on entries that hold loaded data
				if (fresh || reads_known(qr, qc))
					push_query(7'(qr), 8'(qc));
			end
			drain();
		end
		quiet = 0;

		drain();
		$display("covered %0d loads and %0d queries, %0d result beats checked",
			load_cnt, query_cnt, result_cnt);
		$display("sizes from clipped zero up to clipped maxima, windows and offsets at extremes");
		if (fail_cnt == 0 && verdicts_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
